FILE: src/rlac_pkg.sv
// shared constants, codes and beat types for the rotated layer compositor
// no dependencies; used by every module and interface of the block
package rlac_pkg;

    // layer geometry
    localparam int LAYER_WIDTH  = 480;
    localparam int LAYER_HEIGHT = 480;
    localparam int LAYER_DEPTH  = LAYER_WIDTH * LAYER_HEIGHT;

    // fixed field widths
    localparam int ACTION_BITS    = 1;
    localparam int LOAD_ADDR_BITS = 18;
    localparam int BYTE_BITS      = 8;
    localparam int COORD_BITS     = 9;
    localparam int COLOR_BITS     = 24;
    localparam int COEF_BITS      = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // derived widths
    localparam int X_BITS    = $clog2(LAYER_WIDTH);
    localparam int Y_BITS    = $clog2(LAYER_HEIGHT);
    localparam int ADDR_BITS = $clog2(LAYER_DEPTH);

    // mapping arithmetic
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
    localparam int FX_BITS   = 11;
    localparam int PROD_BITS = FX_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 3;
    localparam int Q_BITS    = SUM_BITS - FRAC_BITS;
    localparam int CX        = LAYER_WIDTH / 2;
    localparam int CY        = LAYER_HEIGHT / 2;

    // blend arithmetic
    localparam int MIX_BITS = 16;

    // action codes
    localparam logic [ACTION_BITS-1:0] ACTION_LOAD    = 1'b0;
    localparam logic [ACTION_BITS-1:0] ACTION_COMPOSE = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_COS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIN = 2'd1;

    // register reset values
    localparam logic signed [COEF_BITS-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [COEF_BITS-1:0] SIN_RESET = 16'sd0;

    // input beat as it enters the pipeline
    typedef struct packed {
        logic [ACTION_BITS-1:0]    action;
        logic [LOAD_ADDR_BITS-1:0] load_addr;
        logic [BYTE_BITS-1:0]      load_byte;
        logic [COORD_BITS-1:0]     dest_x;
        logic [COORD_BITS-1:0]     dest_y;
        logic [COLOR_BITS-1:0]     dest_color;
    } in_beat_t;

    // mapped beat: memory address and hit flag (write enable for loads)
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic                   hit;
        logic [ADDR_BITS-1:0]   addr;
        logic [BYTE_BITS-1:0]   load_byte;
        logic [COLOR_BITS-1:0]  color;
    } map_beat_t;

    // fetched beat for compose items
    typedef struct packed {
        logic                  hit;
        logic [COLOR_BITS-1:0] color;
        logic [BYTE_BITS-1:0]  texel;
    } mem_beat_t;

endpackage

FILE: src/rlac_in_if.sv
// input channel of the compositor: valid/ready plus the item fields
// depends on rlac_pkg for field widths
interface rlac_in_if;
    logic                               valid;
    logic                               ready;
    logic [rlac_pkg::ACTION_BITS-1:0]    action;
    logic [rlac_pkg::LOAD_ADDR_BITS-1:0] load_addr;
    logic [rlac_pkg::BYTE_BITS-1:0]      load_byte;
    logic [rlac_pkg::COORD_BITS-1:0]     dest_x;
    logic [rlac_pkg::COORD_BITS-1:0]     dest_y;
    logic [rlac_pkg::COLOR_BITS-1:0]     dest_color;

    modport source (
        output valid, action, load_addr, load_byte, dest_x, dest_y, dest_color,
        input  ready
    );
    modport sink (
        input  valid, action, load_addr, load_byte, dest_x, dest_y, dest_color,
        output ready
    );
endinterface

FILE: src/rlac_out_if.sv
// output channel of the compositor: valid/ready plus the result fields
// depends on rlac_pkg for field widths
interface rlac_out_if;
    logic                           valid;
    logic                           ready;
    logic [rlac_pkg::COLOR_BITS-1:0] out_color;
    logic                           changed;

    modport source (
        output valid, out_color, changed,
        input  ready
    );
    modport sink (
        input  valid, out_color, changed,
        output ready
    );
endinterface

FILE: src/rlac_map.sv
// four-stage coordinate mapper: rotate back, round, range check, address
// depends on rlac_pkg
module rlac_map (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [rlac_pkg::COEF_BITS-1:0] cos_term,
    input  logic signed [rlac_pkg::COEF_BITS-1:0] sin_term,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  rlac_pkg::in_beat_t                    in_beat,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rlac_pkg::map_beat_t                   out_beat
);
    import rlac_pkg::*;

    localparam logic signed [SUM_BITS-1:0] CX_Q     = SUM_BITS'(CX * ONE_Q + HALF_Q);
    localparam logic signed [SUM_BITS-1:0] CY_Q     = SUM_BITS'(CY * ONE_Q + HALF_Q);
    localparam logic signed [SUM_BITS-1:0] NEG_UNIT = SUM_BITS'(-ONE_Q);

    // stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic take1, take2, take3, take4;

    assign take4    = !v4_reg || out_ready;
    assign take3    = !v3_reg || take4;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;
    assign in_ready = take1;

    // common payload carried along the stages
    logic [ACTION_BITS-1:0]    act1_reg, act2_reg, act3_reg;
    logic [LOAD_ADDR_BITS-1:0] la1_reg, la2_reg, la3_reg;
    logic                      lok1_reg, lok2_reg, lok3_reg;
    logic [BYTE_BITS-1:0]      lb1_reg, lb2_reg, lb3_reg;
    logic [COLOR_BITS-1:0]     col1_reg, col2_reg, col3_reg;

    // stage 1: center offsets and the four products
    logic signed [FX_BITS-1:0]   fx, fy;
    logic signed [PROD_BITS-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;

    assign fx = $signed(FX_BITS'(in_beat.dest_x)) - $signed(FX_BITS'(CX));
    assign fy = $signed(FX_BITS'(in_beat.dest_y)) - $signed(FX_BITS'(CY));

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            pxc_reg  <= fx * cos_term;
            pys_reg  <= fy * sin_term;
            pxs_reg  <= fx * sin_term;
            pyc_reg  <= fy * cos_term;
            act1_reg <= in_beat.action;
            la1_reg  <= in_beat.load_addr;
            lok1_reg <= (32'(in_beat.load_addr) < LAYER_DEPTH);
            lb1_reg  <= in_beat.load_byte;
            col1_reg <= in_beat.dest_color;
        end
    end

    // stage 2: source coordinates in Q.14 with the rounding half added
    logic signed [SUM_BITS-1:0] sxq_reg, syq_reg;

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            sxq_reg  <= CX_Q + SUM_BITS'(pxc_reg) + SUM_BITS'(pys_reg);
            syq_reg  <= CY_Q - SUM_BITS'(pxs_reg) + SUM_BITS'(pyc_reg);
            act2_reg <= act1_reg;
            la2_reg  <= la1_reg;
            lok2_reg <= lok1_reg;
            lb2_reg  <= lb1_reg;
            col2_reg <= col1_reg;
        end
    end

    // stage 3: truncate toward zero and check the layer bounds
    logic [Q_BITS-1:0] qx, qy;
    logic              negx, negy, hitx, hity;
    logic [X_BITS-1:0] sx_reg;
    logic [Y_BITS-1:0] sy_reg;
    logic              hit3_reg;

    assign qx   = sxq_reg[SUM_BITS-1:FRAC_BITS];
    assign qy   = syq_reg[SUM_BITS-1:FRAC_BITS];
    assign negx = sxq_reg[SUM_BITS-1];
    assign negy = syq_reg[SUM_BITS-1];
    // a value in (-1, 0) truncates to zero and still hits
    assign hitx = negx ? (sxq_reg > NEG_UNIT) : (qx < Q_BITS'(LAYER_WIDTH));
    assign hity = negy ? (syq_reg > NEG_UNIT) : (qy < Q_BITS'(LAYER_HEIGHT));

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            sx_reg   <= negx ? '0 : qx[X_BITS-1:0];
            sy_reg   <= negy ? '0 : qy[Y_BITS-1:0];
            hit3_reg <= hitx && hity;
            act3_reg <= act2_reg;
            la3_reg  <= la2_reg;
            lok3_reg <= lok2_reg;
            lb3_reg  <= lb2_reg;
            col3_reg <= col2_reg;
        end
    end

    // stage 4: linear address; loads take their own address and range flag
    map_beat_t b4_reg;

    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            b4_reg.action    <= act3_reg;
            b4_reg.load_byte <= lb3_reg;
            b4_reg.color     <= col3_reg;
            if (act3_reg == ACTION_LOAD)
            begin
                b4_reg.hit  <= lok3_reg;
                b4_reg.addr <= ADDR_BITS'(la3_reg);
            end
            else
            begin
                b4_reg.hit  <= hit3_reg;
                b4_reg.addr <= ADDR_BITS'(32'(sy_reg) * LAYER_WIDTH + 32'(sx_reg));
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (take1) v1_reg <= in_valid;
            if (take2) v2_reg <= v1_reg;
            if (take3) v3_reg <= v2_reg;
            if (take4) v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_beat  = b4_reg;

    // a stall reaches the input only when every stage holds a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty stage");

    // a hit always lands inside the layer
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && hit3_reg) |-> (32'(sx_reg) < LAYER_WIDTH && 32'(sy_reg) < LAYER_HEIGHT))
        else $error("hit outside the layer bounds");

    // an accepted address never exceeds the layer
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && b4_reg.hit) |-> (32'(b4_reg.addr) < LAYER_DEPTH))
        else $error("hit address beyond the layer");

    // a stalled output stage keeps its address
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !out_ready) |=> (v4_reg && $stable(b4_reg.addr)))
        else $error("stalled address changed");

endmodule

FILE: src/rlac_mem.sv
// layer memory stage: loads write a byte, compose beats read one
// depends on rlac_pkg; loads end here and only compose beats continue
module rlac_mem (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rlac_pkg::map_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output rlac_pkg::mem_beat_t out_beat
);
    import rlac_pkg::*;

    logic [BYTE_BITS-1:0]  layer_mem_reg [LAYER_DEPTH];
    logic [BYTE_BITS-1:0]  texel_reg;
    logic                  hit_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  v_reg;
    logic                  take;
    logic                  wr_en, rd_en;

    assign take     = !v_reg || out_ready;
    assign in_ready = take;
    assign wr_en    = take && in_valid && (in_beat.action == ACTION_LOAD) && in_beat.hit;
    assign rd_en    = take && in_valid && (in_beat.action == ACTION_COMPOSE);

    // single port: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            layer_mem_reg[in_beat.addr] <= in_beat.load_byte;
        end
        if (rd_en)
        begin
            texel_reg <= layer_mem_reg[in_beat.addr];
        end
    end

    // side payload of the compose beat
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            hit_reg   <= in_beat.hit;
            color_reg <= in_beat.color;
        end
    end

    // valid bit: set only by compose beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (take)
        begin
            v_reg <= in_valid && (in_beat.action == ACTION_COMPOSE);
        end
    end

    assign out_valid      = v_reg;
    assign out_beat.hit   = hit_reg;
    assign out_beat.color = color_reg;
    assign out_beat.texel = texel_reg;

endmodule

FILE: src/rlac_blend.sv
// two-stage blender: per-channel mix products, then divide by 255 and select
// depends on rlac_pkg
module rlac_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rlac_pkg::mem_beat_t            in_beat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rlac_pkg::COLOR_BITS-1:0] out_color,
    output logic                           changed
);
    import rlac_pkg::*;

    logic v6_reg, v7_reg;
    logic take6, take7;

    assign take7    = !v7_reg || out_ready;
    assign take6    = !v6_reg || take7;
    assign in_ready = take6;

    // stage 6: expand nibbles by 17 and form l*a + d*(255-a) per channel
    logic [3:0]            a4, l4;
    logic [7:0]            a8, l8, na8;
    logic [MIX_BITS-1:0]   mix_r_reg, mix_g_reg, mix_b_reg;
    logic                  chg6_reg;
    logic [COLOR_BITS-1:0] col6_reg;

    assign a4  = in_beat.texel[7:4];
    assign l4  = in_beat.texel[3:0];
    assign a8  = {a4, a4};
    assign l8  = {l4, l4};
    assign na8 = ~a8;

    always_ff @(posedge clk)
    begin
        if (take6)
        begin
            mix_r_reg <= MIX_BITS'(l8) * MIX_BITS'(a8)
                         + MIX_BITS'(in_beat.color[23:16]) * MIX_BITS'(na8);
            mix_g_reg <= MIX_BITS'(l8) * MIX_BITS'(a8)
                         + MIX_BITS'(in_beat.color[15:8]) * MIX_BITS'(na8);
            mix_b_reg <= MIX_BITS'(l8) * MIX_BITS'(a8)
                         + MIX_BITS'(in_beat.color[7:0]) * MIX_BITS'(na8);
            chg6_reg  <= in_beat.hit && (a4 != 4'd0);
            col6_reg  <= in_beat.color;
        end
    end

    // stage 7: floor(n/255) as (n + (n >> 8) + 1) >> 8, exact for every n up to 255*255
    logic [MIX_BITS:0]     q_r, q_g, q_b;
    logic [COLOR_BITS-1:0] color7_reg;
    logic                  chg7_reg;

    assign q_r = (MIX_BITS+1)'(mix_r_reg) + (MIX_BITS+1)'(mix_r_reg >> 8) + 1'b1;
    assign q_g = (MIX_BITS+1)'(mix_g_reg) + (MIX_BITS+1)'(mix_g_reg >> 8) + 1'b1;
    assign q_b = (MIX_BITS+1)'(mix_b_reg) + (MIX_BITS+1)'(mix_b_reg >> 8) + 1'b1;

    always_ff @(posedge clk)
    begin
        if (take7)
        begin
            chg7_reg <= chg6_reg;
            if (chg6_reg)
            begin
                color7_reg <= {q_r[15:8], q_g[15:8], q_b[15:8]};
            end
            else
            begin
                color7_reg <= col6_reg;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (take6) v6_reg <= in_valid;
            if (take7) v7_reg <= v6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_color = color7_reg;
    assign changed   = chg7_reg;

endmodule

FILE: src/rotated_layer_alpha_compositor.sv
// Load items write the layer memory and give no result; each compose item gives one.
// Throughput: one item per cycle unless output back-pressure stalls the pipeline.
// The single layer memory port takes one write or one read per cycle in stage 5.
// Reset clears all valid bits and sets cos_term to 16384 and sin_term to 0;
// the layer memory is not cleared and holds whatever was loaded.
// Depends on rlac_pkg, rlac_in_if, rlac_out_if, rlac_map, rlac_mem, rlac_blend.
module rotated_layer_alpha_compositor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rlac_in_if.sink                              in_ch,
    rlac_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [rlac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rlac_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import rlac_pkg::*;

    // rotation registers
    logic signed [COEF_BITS-1:0] cos_reg, sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= COS_RESET;
            sin_reg <= SIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COS: cos_reg <= $signed(cfg_data);
                REG_SIN: sin_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // input beat packing
    in_beat_t in_beat;

    assign in_beat.action     = in_ch.action;
    assign in_beat.load_addr  = in_ch.load_addr;
    assign in_beat.load_byte  = in_ch.load_byte;
    assign in_beat.dest_x     = in_ch.dest_x;
    assign in_beat.dest_y     = in_ch.dest_y;
    assign in_beat.dest_color = in_ch.dest_color;

    // mapper to memory to blender
    map_beat_t map_beat;
    mem_beat_t mem_beat;
    logic      map_valid, map_ready;
    logic      mem_valid, mem_ready;

    rlac_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cos_term  (cos_reg),
        .sin_term  (sin_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_beat   (in_beat),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_beat  (map_beat)
    );

    rlac_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_beat   (map_beat),
        .out_valid (mem_valid),
        .out_ready (mem_ready),
        .out_beat  (mem_beat)
    );

    rlac_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mem_valid),
        .in_ready  (mem_ready),
        .in_beat   (mem_beat),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_color (out_ch.out_color),
        .changed   (out_ch.changed)
    );

endmodule
